[rtl/core/lri_pkg.sv]
// Shared types and constants for the logistic-regression inference core.
// Holds the stream field layout, accumulator limits and the sigmoid lookup table.
// No dependencies.
package lri_pkg;

	localparam int ACC_W     = 40;
	localparam int PROD_W    = 32;
	localparam int CNT_W     = 7;
	localparam int S_TDATA_W = 40;
	localparam int M_TDATA_W = 16;

	localparam logic [CNT_W-1:0] CNT_MAX = 7'd127;

	localparam logic KIND_LOAD    = 1'b0;
	localparam logic KIND_FEATURE = 1'b1;

	localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
	localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

	localparam logic [95:0] EXP_STEP = 96'd4034748382;

	typedef logic [255:0][15:0] sig_table_t;

	// Shift-and-subtract division, used only while the table is elaborated.
	function automatic logic [95:0] div_floor(input logic [95:0] n, input logic [95:0] d);
		logic [95:0] quo;
		logic [95:0] rem;
		int b;
		quo = '0;
		rem = '0;
		for (b = 63; b >= 0; b--) begin
			rem = {rem[94:0], n[b]};
			if (rem >= d) begin
				rem = rem - d;
				quo[b] = 1'b1;
			end
		end
		return quo;
	endfunction

	// Entry i holds sigmoid(-8 + i/16) in Q0.16, built from e^(-m/16) in Q0.32.
	function automatic sig_table_t build_sig_table();
		sig_table_t tbl;
		logic [95:0] e [129];
		logic [95:0] d;
		logic [95:0] num;
		logic [95:0] q;
		int m;
		int i;
		e[0] = 96'd1 << 32;
		for (m = 1; m <= 128; m++) begin
			e[m] = (e[m-1] * EXP_STEP + (96'd1 << 31)) >> 32;
		end
		for (i = 0; i < 256; i++) begin
			if (i >= 128) begin
				d   = (96'd1 << 32) + e[i-128];
				num = 96'd1 << 48;
			end else begin
				d   = (96'd1 << 32) + e[128-i];
				num = e[128-i] << 16;
			end
			q = div_floor(num + (d >> 1), d);
			if (q > 96'd65535) begin
				q = 96'd65535;
			end
			tbl[i] = q[15:0];
		end
		return tbl;
	endfunction

	localparam sig_table_t SIG_TABLE = build_sig_table();

endpackage

[rtl/core/logistic_regression_inference_core.sv]
// Logistic-regression inference core: weight store, multiply-accumulate and sigmoid lookup.
// Depends on lri_pkg for field layout, accumulator limits and the sigmoid table.
// Pipeline: the last feature's sum passes registers s1, s2 and s3 to the output register.
// Throughput: one input transfer per cycle unless a finished sum waits on m_tready, set
// by the single-port weight read and one multiply and one saturating 40-bit add per stage.
// Reset: element counter and accumulator clear, weight_count returns to 1; the weight store
// is not cleared and holds undefined data until written.
module logistic_regression_inference_core #(
	parameter int MAX_WEIGHTS = 64
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          weight_count_we,
	input  logic [lri_pkg::CNT_W-1:0]     weight_count_wdata,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	// Fields from bit 0: weight_index[5:0], weight_value[21:6], feature_value[37:22], zero pad.
	input  logic [lri_pkg::S_TDATA_W-1:0] s_tdata,
	// Fields from bit 0: kind.
	input  logic                          s_tuser,
	input  logic                          s_tlast,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	// Fields from bit 0: probability[15:0].
	output logic [lri_pkg::M_TDATA_W-1:0] m_tdata,
	// Fields from bit 0: count_mismatch.
	output logic                          m_tuser
);

	localparam int AW = (MAX_WEIGHTS > 1) ? $clog2(MAX_WEIGHTS) : 1;
	localparam int UW = ($clog2(MAX_WEIGHTS + 1) > lri_pkg::CNT_W) ?
		$clog2(MAX_WEIGHTS + 1) : lri_pkg::CNT_W;

	logic [5:0]         weight_index;
	logic signed [15:0] weight_value;
	logic signed [15:0] feature_value;

	logic [lri_pkg::CNT_W-1:0] weight_count_q;
	logic [lri_pkg::CNT_W-1:0] cnt_q;
	logic                      over_q;
	logic [lri_pkg::CNT_W-1:0] cnt_next;
	logic                      over_next;
	logic [UW-1:0]             used;
	logic                      en_acc;
	logic                      mismatch;

	logic in_xfer;
	logic feat_xfer;
	logic load_xfer;
	logic slot_ok;

	logic [15:0] weight_mem [MAX_WEIGHTS];

	logic               valid_s1;
	logic               en_s1;
	logic               last_s1;
	logic               mis_s1;
	logic signed [15:0] feat_s1;
	logic signed [15:0] w_s1;

	logic                               valid_s2;
	logic                               en_s2;
	logic                               last_s2;
	logic                               mis_s2;
	logic signed [lri_pkg::PROD_W-1:0]  prod_s2;

	logic                              valid_s3;
	logic                              mis_s3;
	logic signed [lri_pkg::ACC_W-1:0]  sum_s3;

	logic signed [lri_pkg::ACC_W-1:0] acc_q;
	logic signed [lri_pkg::ACC_W:0]   sum_wide;
	logic signed [lri_pkg::ACC_W-1:0] sum_sat;

	logic [27:0] idx_hi;
	logic [7:0]  idx;

	logic        out_valid_q;
	logic [15:0] prob_q;
	logic        mis_q;

	logic out_free;
	logic free3;
	logic free2;
	logic free1;

	assign weight_index  = s_tdata[5:0];
	assign weight_value  = s_tdata[21:6];
	assign feature_value = s_tdata[37:22];

	assign out_free = !out_valid_q || m_tready;
	assign free3    = !valid_s3 || out_free;
	assign free2    = !valid_s2 || !last_s2 || free3;
	assign free1    = !valid_s1 || free2;
	assign s_tready = free1;

	assign in_xfer   = s_tvalid && s_tready;
	assign feat_xfer = in_xfer && (s_tuser == lri_pkg::KIND_FEATURE);
	assign load_xfer = in_xfer && (s_tuser == lri_pkg::KIND_LOAD);
	assign slot_ok   = UW'(weight_index) < UW'(MAX_WEIGHTS);

	always_comb begin
		used = (UW'(weight_count_q) > UW'(MAX_WEIGHTS)) ? UW'(MAX_WEIGHTS) : UW'(weight_count_q);
		en_acc = !over_q && (UW'(cnt_q) < used);
		if (cnt_q >= lri_pkg::CNT_MAX) begin
			cnt_next  = cnt_q;
			over_next = 1'b1;
		end else begin
			cnt_next  = cnt_q + 1'b1;
			over_next = over_q;
		end
		mismatch = over_next || (cnt_next != weight_count_q);
	end

	always_comb begin
		sum_wide = (lri_pkg::ACC_W+1)'(acc_q) + (lri_pkg::ACC_W+1)'(prod_s2);
		if (!en_s2) begin
			sum_sat = acc_q;
		end else if (sum_wide[lri_pkg::ACC_W] != sum_wide[lri_pkg::ACC_W-1]) begin
			sum_sat = sum_wide[lri_pkg::ACC_W] ? lri_pkg::ACC_MIN : lri_pkg::ACC_MAX;
		end else begin
			sum_sat = sum_wide[lri_pkg::ACC_W-1:0];
		end
	end

	always_comb begin
		idx_hi = sum_s3[lri_pkg::ACC_W-1:12];
		priority if (idx_hi[27] && !(&idx_hi[27:7])) begin
			idx = 8'd0;
		end else if (!idx_hi[27] && (|idx_hi[26:7])) begin
			idx = 8'd255;
		end else begin
			idx = {~idx_hi[7], idx_hi[6:0]};
		end
	end

	always_ff @(posedge clk) begin
		if (load_xfer && slot_ok) begin
			weight_mem[AW'(weight_index)] <= weight_value;
		end
		if (feat_xfer && en_acc) begin
			w_s1 <= weight_mem[AW'(cnt_q)];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			weight_count_q <= 7'd1;
			cnt_q          <= '0;
			over_q         <= 1'b0;
			acc_q          <= '0;
			valid_s1       <= 1'b0;
			valid_s2       <= 1'b0;
			valid_s3       <= 1'b0;
			out_valid_q    <= 1'b0;
		end else begin
			if (weight_count_we) begin
				weight_count_q <= weight_count_wdata;
			end
			if (feat_xfer) begin
				if (s_tlast) begin
					cnt_q  <= '0;
					over_q <= 1'b0;
				end else begin
					cnt_q  <= cnt_next;
					over_q <= over_next;
				end
			end
			if (valid_s2 && free2) begin
				acc_q <= last_s2 ? '0 : sum_sat;
			end
			if (free1) begin
				valid_s1 <= feat_xfer;
			end
			if (free2) begin
				valid_s2 <= valid_s1;
			end
			if (free3) begin
				valid_s3 <= valid_s2 && last_s2;
			end
			if (out_free) begin
				out_valid_q <= valid_s3;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (feat_xfer) begin
			feat_s1 <= feature_value;
			en_s1   <= en_acc;
			last_s1 <= s_tlast;
			mis_s1  <= mismatch;
		end
		if (free2 && valid_s1) begin
			prod_s2 <= feat_s1 * w_s1;
			en_s2   <= en_s1;
			last_s2 <= last_s1;
			mis_s2  <= mis_s1;
		end
		if (free3 && valid_s2 && last_s2) begin
			sum_s3 <= sum_sat;
			mis_s3 <= mis_s2;
		end
		if (out_free && valid_s3) begin
			prob_q <= lri_pkg::SIG_TABLE[idx];
			mis_q  <= mis_s3;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = prob_q;
	assign m_tuser  = mis_q;

	a_count_clears_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		feat_xfer && s_tlast |=> cnt_q == '0 && !over_q)
		else $error("element counter not cleared after the last feature transfer");

	a_over_only_at_max: assert property (@(posedge clk) disable iff (!arst_n)
		over_q |-> cnt_q == lri_pkg::CNT_MAX)
		else $error("counter overflow flag set below the counter limit");

	a_acc_clears_after_sum: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && free2 && last_s2 |=> acc_q == '0)
		else $error("accumulator not cleared after a finished sum");

	a_result_from_last: assert property (@(posedge clk) disable iff (!arst_n)
		$past(free3) && valid_s3 |-> $past(valid_s2 && last_s2))
		else $error("result stage loaded without a last feature");

endmodule
